// ----- sv/segregated_free_list_allocator_top_assert.svh -----
// ----------------------------------------------------------------------------
// Segregated free-list allocator - assertion macros
// Shared concurrent check wrappers, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SEGREGATED_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH
`define SEGREGATED_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication
`define SFLA_ASSERT_HOLD(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfla: same-cycle check failed");

// next-cycle implication
`define SFLA_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfla: next-cycle check failed");

`endif

// ----- sv/sfla_pkg.sv -----
// ----------------------------------------------------------------------------
// Segregated free-list allocator - package
// Widths, size-class function, controller states, command and status types.
// ----------------------------------------------------------------------------
package sfla_pkg;

    localparam int HEAP_WORDS  = 65536;
    localparam int ADDR_W      = 16;
    localparam int SIZE_W      = 17;
    localparam int WORDS_W     = 18;
    localparam int BYTES_W     = 20;
    localparam int SMALL_LIMIT = 64;
    localparam int SMALL_DEPTH = SMALL_LIMIT + 1;
    localparam int SMALL_AW    = $clog2(SMALL_DEPTH);
    localparam int BIG_CLASSES = 256;
    localparam int CLASS_W     = $clog2(BIG_CLASSES);
    localparam int MAX_SCAN    = 16;
    localparam int SCAN_W      = 5;
    localparam int COUNT_W     = 16;
    localparam int META_W      = SIZE_W + 1 + ADDR_W;
    localparam int FROM_W      = CLASS_W + 1;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SETUP, ST_SMALL_RD, ST_SMALL_META, ST_SMALL_WB, ST_FIND,
        ST_POP_RD, ST_POP_META, ST_POP_WB, ST_SCAN_HEAD, ST_SCAN_LATCH,
        ST_SCAN_TEST, ST_SCAN_EVAL, ST_SPLIT, ST_PUSH_RD, ST_PUSH_WR,
        ST_BUMP, ST_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_IDLE, OP_LATCH, OP_ALLOC_SETUP, OP_FREE_SETUP, OP_SMALL_RD,
        OP_SMALL_META, OP_SMALL_WB, OP_FIND, OP_POP_RD, OP_POP_META, OP_POP_WB,
        OP_SCAN_HEAD, OP_SCAN_LATCH, OP_SCAN_TEST, OP_SCAN_EVAL, OP_SPLIT,
        OP_PUSH_RD, OP_PUSH_WR, OP_BUMP, OP_DONE
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic is_free;
        logic free_ok;
        logic is_small;
        logic small_hit;
        logic scan_go;
        logic fit;
        logic ff_found;
        logic ff_end;
        logic split_go;
        logic bump_ok;
    } status_t;

    // top bit k gives class 8k plus the three bits below it
    function automatic logic [CLASS_W-1:0] class_of(input logic [WORDS_W-1:0] words);
        logic [4:0]         k;
        logic [WORDS_W-1:0] sh;
        logic [8:0]         c;
        k = '0;
        for (int i = 0; i < WORDS_W; i++)
        begin
            if (words[i])
            begin
                k = 5'(i);
            end
        end
        sh = words >> (k - 5'd3);
        c  = {1'b0, k, 3'b000} | {6'b0, sh[2:0]};
        if (c >= 9'(BIG_CLASSES))
        begin
            c = 9'(BIG_CLASSES - 1);
        end
        return c[CLASS_W-1:0];
    endfunction

endpackage

// ----- sv/sfla_ram.sv -----
// ----------------------------------------------------------------------------
// Segregated free-list allocator - generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sfla_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/sfla_ctrl.sv -----
// ----------------------------------------------------------------------------
// Segregated free-list allocator - controller
// Sequences list pops, class scan, bitmap search, pushes and bump fallback.
// ----------------------------------------------------------------------------
module sfla_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  sfla_pkg::status_t sts,
    output sfla_pkg::cmd_t    cmd
);

    sfla_pkg::state_t state_reg;
    sfla_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sfla_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = sfla_pkg::OP_IDLE;
        unique case (state_reg)
            sfla_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = sfla_pkg::OP_LATCH;
                    state_next = sfla_pkg::ST_SETUP;
                end
            end
            sfla_pkg::ST_SETUP:
            begin
                if (sts.is_free)
                begin
                    cmd.op     = sfla_pkg::OP_FREE_SETUP;
                    state_next = sts.free_ok ? sfla_pkg::ST_PUSH_RD : sfla_pkg::ST_DONE;
                end
                else
                begin
                    cmd.op = sfla_pkg::OP_ALLOC_SETUP;
                    if (!sts.is_small)
                    begin
                        state_next = sfla_pkg::ST_SCAN_HEAD;
                    end
                    else if (sts.small_hit)
                    begin
                        state_next = sfla_pkg::ST_SMALL_RD;
                    end
                    else
                    begin
                        state_next = sfla_pkg::ST_FIND;
                    end
                end
            end
            sfla_pkg::ST_SMALL_RD:
            begin
                cmd.op     = sfla_pkg::OP_SMALL_RD;
                state_next = sfla_pkg::ST_SMALL_META;
            end
            sfla_pkg::ST_SMALL_META:
            begin
                cmd.op     = sfla_pkg::OP_SMALL_META;
                state_next = sfla_pkg::ST_SMALL_WB;
            end
            sfla_pkg::ST_SMALL_WB:
            begin
                cmd.op     = sfla_pkg::OP_SMALL_WB;
                state_next = sfla_pkg::ST_DONE;
            end
            sfla_pkg::ST_FIND:
            begin
                cmd.op = sfla_pkg::OP_FIND;
                if (sts.ff_found)
                begin
                    state_next = sfla_pkg::ST_POP_RD;
                end
                else if (sts.ff_end)
                begin
                    state_next = sfla_pkg::ST_BUMP;
                end
            end
            sfla_pkg::ST_POP_RD:
            begin
                cmd.op     = sfla_pkg::OP_POP_RD;
                state_next = sfla_pkg::ST_POP_META;
            end
            sfla_pkg::ST_POP_META:
            begin
                cmd.op     = sfla_pkg::OP_POP_META;
                state_next = sfla_pkg::ST_POP_WB;
            end
            sfla_pkg::ST_POP_WB:
            begin
                cmd.op     = sfla_pkg::OP_POP_WB;
                state_next = sfla_pkg::ST_SPLIT;
            end
            sfla_pkg::ST_SCAN_HEAD:
            begin
                cmd.op     = sfla_pkg::OP_SCAN_HEAD;
                state_next = sfla_pkg::ST_SCAN_LATCH;
            end
            sfla_pkg::ST_SCAN_LATCH:
            begin
                cmd.op     = sfla_pkg::OP_SCAN_LATCH;
                state_next = sfla_pkg::ST_SCAN_TEST;
            end
            sfla_pkg::ST_SCAN_TEST:
            begin
                cmd.op     = sfla_pkg::OP_SCAN_TEST;
                state_next = sts.scan_go ? sfla_pkg::ST_SCAN_EVAL : sfla_pkg::ST_FIND;
            end
            sfla_pkg::ST_SCAN_EVAL:
            begin
                cmd.op     = sfla_pkg::OP_SCAN_EVAL;
                state_next = sts.fit ? sfla_pkg::ST_SPLIT : sfla_pkg::ST_SCAN_TEST;
            end
            sfla_pkg::ST_SPLIT:
            begin
                cmd.op     = sfla_pkg::OP_SPLIT;
                state_next = sts.split_go ? sfla_pkg::ST_PUSH_RD : sfla_pkg::ST_DONE;
            end
            sfla_pkg::ST_PUSH_RD:
            begin
                cmd.op     = sfla_pkg::OP_PUSH_RD;
                state_next = sfla_pkg::ST_PUSH_WR;
            end
            sfla_pkg::ST_PUSH_WR:
            begin
                cmd.op     = sfla_pkg::OP_PUSH_WR;
                state_next = sfla_pkg::ST_DONE;
            end
            sfla_pkg::ST_BUMP:
            begin
                cmd.op     = sfla_pkg::OP_BUMP;
                state_next = sfla_pkg::ST_DONE;
            end
            sfla_pkg::ST_DONE:
            begin
                cmd.op     = sfla_pkg::OP_DONE;
                state_next = sfla_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = sfla_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != sfla_pkg::ST_IDLE);

endmodule

// ----- sv/sfla_dp.sv -----
// ----------------------------------------------------------------------------
// Segregated free-list allocator - datapath
// List heads, class bitmap, block metadata RAM, bump pointer and counters.
// ----------------------------------------------------------------------------
`include "segregated_free_list_allocator_top_assert.svh"

module sfla_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  sfla_pkg::cmd_t                       cmd,
    output sfla_pkg::status_t                    sts,
    input  logic                                 kind,
    input  logic [sfla_pkg::BYTES_W-1:0]         request_bytes,
    input  logic [sfla_pkg::ADDR_W-1:0]          block_addr,
    input  logic [sfla_pkg::SIZE_W-1:0]          block_words,
    input  logic                                 cfg_we,
    input  logic [sfla_pkg::SCAN_W-1:0]          cfg_wdata,
    output logic                                 done,
    output logic                                 status,
    output logic [sfla_pkg::ADDR_W-1:0]          granted_addr,
    output logic [sfla_pkg::SIZE_W-1:0]          granted_words,
    output logic [sfla_pkg::COUNT_W-1:0]         live_blocks,
    output logic [sfla_pkg::COUNT_W-1:0]         peak_blocks
);

    localparam int AW  = sfla_pkg::ADDR_W;
    localparam int SW  = sfla_pkg::SIZE_W;
    localparam int WW  = sfla_pkg::WORDS_W;
    localparam int CW  = sfla_pkg::CLASS_W;
    localparam int CNW = sfla_pkg::COUNT_W;
    localparam int SAW = sfla_pkg::SMALL_AW;
    localparam int NC  = sfla_pkg::BIG_CLASSES;
    localparam int NS  = sfla_pkg::SMALL_DEPTH;
    localparam int FW  = sfla_pkg::FROM_W;

    // control state
    logic [sfla_pkg::SCAN_W-1:0] scan_limit_reg, scan_limit_next;
    logic [SW-1:0]               bump_reg, bump_next;
    logic [CNW-1:0]              live_reg, live_next;
    logic [CNW-1:0]              peak_reg, peak_next;
    logic [NC-1:0]               map_reg, map_next;
    logic [NS-1:0]               small_valid_reg, small_valid_next;
    logic                        done_reg, done_next;

    // working registers
    logic                        kind_reg, kind_next;
    logic [WW-1:0]               words_reg, words_next;
    logic [AW-1:0]               baddr_reg, baddr_next;
    logic [SW-1:0]               bwords_reg, bwords_next;
    logic                        ok_reg, ok_next;
    logic [AW-1:0]               gaddr_reg, gaddr_next;
    logic [CW-1:0]               cls_reg, cls_next;
    logic [FW-1:0]               from_reg, from_next;
    logic                        cur_valid_reg, cur_valid_next;
    logic [AW-1:0]               cur_addr_reg, cur_addr_next;
    logic                        prev_valid_reg, prev_valid_next;
    logic [AW-1:0]               prev_addr_reg, prev_addr_next;
    logic [SW-1:0]               prev_size_reg, prev_size_next;
    logic [sfla_pkg::SCAN_W-1:0] n_reg, n_next;
    logic [AW-1:0]               blk_addr_reg, blk_addr_next;
    logic [SW-1:0]               blk_size_reg, blk_size_next;
    logic [AW-1:0]               push_addr_reg, push_addr_next;
    logic [SW-1:0]               push_size_reg, push_size_next;
    logic                        status_reg, status_next;
    logic [AW-1:0]               granted_addr_reg, granted_addr_next;
    logic [SW-1:0]               granted_words_reg, granted_words_next;

    // RAM ports
    logic                        small_we, big_we, meta_we;
    logic [SAW-1:0]              small_waddr, small_raddr;
    logic [AW-1:0]               small_wdata, small_rdata;
    logic [CW-1:0]               big_waddr, big_raddr;
    logic [AW-1:0]               big_wdata, big_rdata;
    logic [AW-1:0]               meta_waddr, meta_raddr;
    logic [sfla_pkg::META_W-1:0] meta_wdata, meta_rdata;

    // decode
    logic [WW-1:0]               words_raw, words_rnd;
    logic [CW-1:0]               class_w, class_p;
    logic [sfla_pkg::SCAN_W-1:0] limit;
    logic [SW-1:0]               m_size;
    logic                        m_nvalid;
    logic [AW-1:0]               m_naddr;
    logic [63:0]                 map_word, map_masked;
    logic [5:0]                  ffs_idx;
    logic                        push_small;
    logic                        head_valid;
    logic [AW-1:0]               head_addr;

    sfla_ram #(.WIDTH(AW), .DEPTH(NS)) u_small_ram (
        .clk   (clk),
        .we    (small_we),
        .waddr (small_waddr),
        .wdata (small_wdata),
        .raddr (small_raddr),
        .rdata (small_rdata)
    );

    sfla_ram #(.WIDTH(AW), .DEPTH(NC)) u_big_ram (
        .clk   (clk),
        .we    (big_we),
        .waddr (big_waddr),
        .wdata (big_wdata),
        .raddr (big_raddr),
        .rdata (big_rdata)
    );

    sfla_ram #(.WIDTH(sfla_pkg::META_W), .DEPTH(sfla_pkg::HEAP_WORDS)) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .raddr (meta_raddr),
        .rdata (meta_rdata)
    );

    always_comb
    begin
        words_raw = WW'((21'(request_bytes) + 21'd7) >> 3);
        words_rnd = (words_raw < WW'(2)) ? WW'(2) : words_raw;
        class_w   = sfla_pkg::class_of(words_reg);
        class_p   = sfla_pkg::class_of({1'b0, push_size_reg});
        limit     = (scan_limit_reg > sfla_pkg::SCAN_W'(sfla_pkg::MAX_SCAN))
                    ? sfla_pkg::SCAN_W'(sfla_pkg::MAX_SCAN) : scan_limit_reg;
        m_size    = meta_rdata[sfla_pkg::META_W-1 -: SW];
        m_nvalid  = meta_rdata[AW];
        m_naddr   = meta_rdata[AW-1:0];

        map_word   = map_reg[from_reg[CW-1:6]*64 +: 64];
        map_masked = map_word & (~64'd0 << from_reg[5:0]);
        ffs_idx    = '0;
        for (int i = 63; i >= 0; i--)
        begin
            if (map_masked[i])
            begin
                ffs_idx = 6'(i);
            end
        end

        push_small = (push_size_reg <= SW'(sfla_pkg::SMALL_LIMIT));
        head_valid = push_small ? small_valid_reg[push_size_reg[SAW-1:0]] : map_reg[class_p];
        head_addr  = push_small ? small_rdata : big_rdata;

        sts.is_free   = kind_reg;
        sts.free_ok   = (bwords_reg >= SW'(2))
                        && ((18'(baddr_reg) + 18'(bwords_reg)) <= 18'(sfla_pkg::HEAP_WORDS));
        sts.is_small  = (words_reg <= WW'(sfla_pkg::SMALL_LIMIT));
        sts.small_hit = sts.is_small && small_valid_reg[words_reg[SAW-1:0]];
        sts.scan_go   = cur_valid_reg && (n_reg < limit);
        sts.fit       = (WW'(m_size) >= words_reg);
        sts.ff_end    = from_reg[FW-1];
        sts.ff_found  = !from_reg[FW-1] && (|map_masked);
        sts.split_go  = ((19'(blk_size_reg)) >= (19'(words_reg) + 19'd2))
                        && ((19'(blk_addr_reg) + 19'(words_reg)) < 19'(sfla_pkg::HEAP_WORDS));
        sts.bump_ok   = (19'(words_reg) + 19'(bump_reg)) <= 19'(sfla_pkg::HEAP_WORDS);
    end

    always_comb
    begin
        scan_limit_next    = cfg_we ? cfg_wdata : scan_limit_reg;
        bump_next          = bump_reg;
        live_next          = live_reg;
        peak_next          = peak_reg;
        map_next           = map_reg;
        small_valid_next   = small_valid_reg;
        done_next          = 1'b0;
        kind_next          = kind_reg;
        words_next         = words_reg;
        baddr_next         = baddr_reg;
        bwords_next        = bwords_reg;
        ok_next            = ok_reg;
        gaddr_next         = gaddr_reg;
        cls_next           = cls_reg;
        from_next          = from_reg;
        cur_valid_next     = cur_valid_reg;
        cur_addr_next      = cur_addr_reg;
        prev_valid_next    = prev_valid_reg;
        prev_addr_next     = prev_addr_reg;
        prev_size_next     = prev_size_reg;
        n_next             = n_reg;
        blk_addr_next      = blk_addr_reg;
        blk_size_next      = blk_size_reg;
        push_addr_next     = push_addr_reg;
        push_size_next     = push_size_reg;
        status_next        = status_reg;
        granted_addr_next  = granted_addr_reg;
        granted_words_next = granted_words_reg;

        small_we    = 1'b0;
        small_waddr = words_reg[SAW-1:0];
        small_wdata = m_naddr;
        small_raddr = words_reg[SAW-1:0];
        big_we      = 1'b0;
        big_waddr   = cls_reg;
        big_wdata   = m_naddr;
        big_raddr   = cls_reg;
        meta_we     = 1'b0;
        meta_waddr  = push_addr_reg;
        meta_wdata  = {push_size_reg, head_valid, head_addr};
        meta_raddr  = cur_addr_reg;

        unique case (cmd.op)
            sfla_pkg::OP_IDLE:
            begin
            end
            sfla_pkg::OP_LATCH:
            begin
                kind_next   = kind;
                words_next  = words_rnd;
                baddr_next  = block_addr;
                bwords_next = block_words;
                ok_next     = 1'b0;
                gaddr_next  = '0;
            end
            sfla_pkg::OP_ALLOC_SETUP:
            begin
                cls_next        = class_w;
                from_next       = '0;
                cur_valid_next  = map_reg[class_w];
                prev_valid_next = 1'b0;
                n_next          = '0;
            end
            sfla_pkg::OP_FREE_SETUP:
            begin
                push_addr_next = baddr_reg;
                push_size_next = bwords_reg;
            end
            sfla_pkg::OP_SMALL_RD:
            begin
            end
            sfla_pkg::OP_SMALL_META:
            begin
                blk_addr_next = small_rdata;
                meta_raddr    = small_rdata;
            end
            sfla_pkg::OP_SMALL_WB:
            begin
                small_we                               = 1'b1;
                small_valid_next[words_reg[SAW-1:0]]   = m_nvalid;
                ok_next                                = 1'b1;
                gaddr_next                             = blk_addr_reg;
            end
            sfla_pkg::OP_FIND:
            begin
                if (sts.ff_found)
                begin
                    cls_next = {from_reg[CW-1:6], ffs_idx};
                end
                else if (!sts.ff_end)
                begin
                    from_next = {from_reg[FW-1:6] + 3'd1, 6'd0};
                end
            end
            sfla_pkg::OP_POP_RD, sfla_pkg::OP_SCAN_HEAD:
            begin
            end
            sfla_pkg::OP_POP_META:
            begin
                blk_addr_next = big_rdata;
                meta_raddr    = big_rdata;
            end
            sfla_pkg::OP_POP_WB:
            begin
                big_we            = 1'b1;
                map_next[cls_reg] = m_nvalid;
                blk_size_next     = m_size;
            end
            sfla_pkg::OP_SCAN_LATCH:
            begin
                cur_addr_next = big_rdata;
            end
            sfla_pkg::OP_SCAN_TEST:
            begin
                if (!sts.scan_go)
                begin
                    from_next = FW'(cls_reg) + FW'(1);
                end
            end
            sfla_pkg::OP_SCAN_EVAL:
            begin
                if (sts.fit)
                begin
                    if (prev_valid_reg)
                    begin
                        meta_we    = 1'b1;
                        meta_waddr = prev_addr_reg;
                        meta_wdata = {prev_size_reg, m_nvalid, m_naddr};
                    end
                    else
                    begin
                        big_we            = 1'b1;
                        map_next[cls_reg] = m_nvalid;
                    end
                    blk_addr_next = cur_addr_reg;
                    blk_size_next = m_size;
                end
                else
                begin
                    prev_valid_next = 1'b1;
                    prev_addr_next  = cur_addr_reg;
                    prev_size_next  = m_size;
                    cur_valid_next  = m_nvalid;
                    cur_addr_next   = m_naddr;
                    n_next          = n_reg + 1'b1;
                end
            end
            sfla_pkg::OP_SPLIT:
            begin
                ok_next        = 1'b1;
                gaddr_next     = blk_addr_reg;
                push_addr_next = blk_addr_reg + words_reg[AW-1:0];
                push_size_next = blk_size_reg - words_reg[SW-1:0];
            end
            sfla_pkg::OP_PUSH_RD:
            begin
                small_raddr = push_size_reg[SAW-1:0];
                big_raddr   = class_p;
            end
            sfla_pkg::OP_PUSH_WR:
            begin
                meta_we = 1'b1;
                if (push_small)
                begin
                    small_we                                  = 1'b1;
                    small_waddr                               = push_size_reg[SAW-1:0];
                    small_wdata                               = push_addr_reg;
                    small_valid_next[push_size_reg[SAW-1:0]] = 1'b1;
                end
                else
                begin
                    big_we            = 1'b1;
                    big_waddr         = class_p;
                    big_wdata         = push_addr_reg;
                    map_next[class_p] = 1'b1;
                end
            end
            sfla_pkg::OP_BUMP:
            begin
                if (sts.bump_ok)
                begin
                    ok_next    = 1'b1;
                    gaddr_next = bump_reg[AW-1:0];
                    bump_next  = SW'(19'(bump_reg) + 19'(words_reg));
                end
            end
            sfla_pkg::OP_DONE:
            begin
                if (!kind_reg)
                begin
                    if (ok_reg && (live_reg != {CNW{1'b1}}))
                    begin
                        live_next = live_reg + 1'b1;
                    end
                end
                else if (sts.free_ok && (live_reg != '0))
                begin
                    live_next = live_reg - 1'b1;
                end
                peak_next          = (live_next > peak_reg) ? live_next : peak_reg;
                status_next        = !kind_reg && !ok_reg;
                granted_addr_next  = ok_reg ? gaddr_reg : '0;
                granted_words_next = ok_reg ? words_reg[SW-1:0] : '0;
                done_next          = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_limit_reg  <= sfla_pkg::SCAN_W'(sfla_pkg::MAX_SCAN);
            bump_reg        <= '0;
            live_reg        <= '0;
            peak_reg        <= '0;
            map_reg         <= '0;
            small_valid_reg <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            scan_limit_reg  <= scan_limit_next;
            bump_reg        <= bump_next;
            live_reg        <= live_next;
            peak_reg        <= peak_next;
            map_reg         <= map_next;
            small_valid_reg <= small_valid_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg          <= kind_next;
        words_reg         <= words_next;
        baddr_reg         <= baddr_next;
        bwords_reg        <= bwords_next;
        ok_reg            <= ok_next;
        gaddr_reg         <= gaddr_next;
        cls_reg           <= cls_next;
        from_reg          <= from_next;
        cur_valid_reg     <= cur_valid_next;
        cur_addr_reg      <= cur_addr_next;
        prev_valid_reg    <= prev_valid_next;
        prev_addr_reg     <= prev_addr_next;
        prev_size_reg     <= prev_size_next;
        n_reg             <= n_next;
        blk_addr_reg      <= blk_addr_next;
        blk_size_reg      <= blk_size_next;
        push_addr_reg     <= push_addr_next;
        push_size_reg     <= push_size_next;
        status_reg        <= status_next;
        granted_addr_reg  <= granted_addr_next;
        granted_words_reg <= granted_words_next;
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign granted_addr  = granted_addr_reg;
    assign granted_words = granted_words_reg;
    assign live_blocks   = live_reg;
    assign peak_blocks   = peak_reg;

    `SFLA_ASSERT_NEXT(a_done_single, done_reg, !done_reg)
    `SFLA_ASSERT_HOLD(a_peak_ge_live, done_reg, peak_reg >= live_reg)
    `SFLA_ASSERT_HOLD(a_fail_no_grant, done_reg && status_reg,
                      granted_addr_reg == '0 && granted_words_reg == '0)

endmodule

// ----- sv/segregated_free_list_allocator_top.sv -----
// ----------------------------------------------------------------------------
// Segregated free-list allocator - top level
// Heap allocator: exact-size small lists, scanned big classes, bump pointer.
//
//  channel  | ports                                                 | handshake
//  request  | kind, request_bytes, block_addr, block_words          | start & !busy
//  result   | status, granted_addr, granted_words, live/peak_blocks | done, 1 cycle
//  config   | cfg_wdata (scan_limit)                                | cfg_we
//
// A new request can be taken in the result cycle. Free: setup, push read,
// push write. Rejected free: setup only. Small hit: setup, list read,
// metadata read, write-back. Small miss: bitmap search, pop and push, or bump.
// Big request: scan of up to scan_limit (at most 16) list entries, then bitmap
// search, pop and push; every list step waits on a registered metadata read.
// Results are registered, shown with done, and cannot be stalled. Reset
// empties every list; no clearing pass.
// ----------------------------------------------------------------------------
module segregated_free_list_allocator_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 kind,
    input  logic [sfla_pkg::BYTES_W-1:0]         request_bytes,
    input  logic [sfla_pkg::ADDR_W-1:0]          block_addr,
    input  logic [sfla_pkg::SIZE_W-1:0]          block_words,
    input  logic                                 cfg_we,
    input  logic [sfla_pkg::SCAN_W-1:0]          cfg_wdata,
    output logic                                 done,
    output logic                                 status,
    output logic [sfla_pkg::ADDR_W-1:0]          granted_addr,
    output logic [sfla_pkg::SIZE_W-1:0]          granted_words,
    output logic [sfla_pkg::COUNT_W-1:0]         live_blocks,
    output logic [sfla_pkg::COUNT_W-1:0]         peak_blocks
);

    sfla_pkg::cmd_t    cmd;
    sfla_pkg::status_t sts;

    sfla_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    sfla_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .kind          (kind),
        .request_bytes (request_bytes),
        .block_addr    (block_addr),
        .block_words   (block_words),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .done          (done),
        .status        (status),
        .granted_addr  (granted_addr),
        .granted_words (granted_words),
        .live_blocks   (live_blocks),
        .peak_blocks   (peak_blocks)
    );

endmodule
